// ----- hw/rtl/qslerp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, fixed-point widths and the arctangent table for the quaternion slerp block.
// Used by the square-root, CORDIC and divider cells and by the top level; no dependencies.

package qslerp_pkg;

  // Trig domain has 30 fraction bits.
  localparam int TRIG_FRAC = 30;
  // CORDIC working width (signed), comfortably above the largest angle and vector length.
  localparam int ANG_W = 34;
  // Square root: one result bit per cell, radicand up to 2^60.
  localparam int SQ_STEPS = 31;
  localparam int SQ_W = 62;
  // Divider: quotient bits and remainder width.
  localparam int DIV_Q_W = 40;
  localparam int DIV_R_W = 32;
  // Weight width: quotient magnitude plus sign.
  localparam int K_W = DIV_Q_W + 1;

  localparam logic [15:0] T_ONE = 16'd32768;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] start_c0;
    logic signed [15:0] start_c1;
    logic signed [15:0] start_c2;
    logic signed [15:0] start_c3;
    logic signed [15:0] end_c0;
    logic signed [15:0] end_c1;
    logic signed [15:0] end_c2;
    logic signed [15:0] end_c3;
    logic [15:0]        blend_fraction;
  } qs_in_t;

  typedef struct packed {
    logic signed [15:0] out_c0;
    logic signed [15:0] out_c1;
    logic signed [15:0] out_c2;
    logic signed [15:0] out_c3;
  } qs_out_t;

  // Operands that ride along the whole pipeline.
  typedef struct packed {
    logic [3:0][15:0] s;
    logic [3:0][16:0] e;
    logic [15:0]      t;
    logic [15:0]      u;
    logic             lin;
  } qs_side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } qs_cordic_t;

  typedef struct packed {
    logic               neg;
    logic [DIV_R_W-1:0] rem;
    logic [DIV_Q_W-1:0] quo;
  } qs_div_t;

  // atan(2^-i) with 30 fraction bits, rounded.
  function automatic logic [30:0] atan_q30(input int idx);
    logic [30:0] r;
    case (idx)
      0:  r = 31'd843314857;
      1:  r = 31'd497837830;
      2:  r = 31'd263043837;
      3:  r = 31'd133525159;
      4:  r = 31'd67021687;
      5:  r = 31'd33543516;
      6:  r = 31'd16775851;
      7:  r = 31'd8388437;
      8:  r = 31'd4194283;
      9:  r = 31'd2097149;
      10: r = 31'd1048576;
      11: r = 31'd524288;
      12: r = 31'd262144;
      13: r = 31'd131072;
      14: r = 31'd65536;
      15: r = 31'd32768;
      16: r = 31'd16384;
      17: r = 31'd8192;
      18: r = 31'd4096;
      19: r = 31'd2048;
      20: r = 31'd1024;
      21: r = 31'd512;
      22: r = 31'd256;
      23: r = 31'd128;
      24: r = 31'd64;
      25: r = 31'd32;
      26: r = 31'd16;
      27: r = 31'd8;
      28: r = 31'd4;
      29: r = 31'd2;
      30: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/qslerp_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One bit of a pipelined integer square root (restoring, one result bit per cell).
// Depends on qslerp_pkg.

module qslerp_sqrt_cell #(
  parameter int STEP    = 0,
  parameter int CARRY_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [qslerp_pkg::SQ_W-1:0] in_rem,
  input  logic [qslerp_pkg::SQ_W-1:0] in_res,
  input  logic [CARRY_W-1:0]         in_carry,
  output logic                       out_vld,
  output logic [qslerp_pkg::SQ_W-1:0] out_rem,
  output logic [qslerp_pkg::SQ_W-1:0] out_res,
  output logic [CARRY_W-1:0]         out_carry
);
  import qslerp_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [SQ_W-1:0] trial;
  logic            ge;
  logic [SQ_W-1:0] rem_nxt, res_nxt;
  logic            vld_r;
  logic [SQ_W-1:0] rem_r, res_r;
  logic [CARRY_W-1:0] carry_r;

  always_comb begin
    trial = in_res + BIT;
    ge    = in_rem >= trial;
    if (ge) begin
      rem_nxt = in_rem - trial;
      res_nxt = (in_res >> 1) + BIT;
    end else begin
      rem_nxt = in_rem;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rem_r   <= rem_nxt;
      res_r   <= res_nxt;
      carry_r <= in_carry;
    end
  end

  assign out_vld   = vld_r;
  assign out_rem   = rem_r;
  assign out_res   = res_r;
  assign out_carry = carry_r;

endmodule

// ----- hw/rtl/qslerp_cordic_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC micro-rotation for one or more lanes, in vectoring or rotation mode.
// Depends on qslerp_pkg for the lane type and the arctangent table.

module qslerp_cordic_cell #(
  parameter int STEP      = 0,
  parameter int LANES     = 1,
  parameter bit VECTORING = 1'b1,
  parameter int CARRY_W   = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  qslerp_pkg::qs_cordic_t [LANES-1:0]    in_lane,
  input  logic [CARRY_W-1:0]                    in_carry,
  output logic                                  out_vld,
  output qslerp_pkg::qs_cordic_t [LANES-1:0]    out_lane,
  output logic [CARRY_W-1:0]                    out_carry
);
  import qslerp_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_K = ANG_W'(atan_q30(STEP));

  logic               vld_r;
  logic [CARRY_W-1:0] carry_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [ANG_W-1:0] x, y, z, dx, dy;
    logic                    pos;
    qs_cordic_t              lane_nxt, lane_r;

    // Vectoring drives y toward zero; rotation drives z toward zero.
    always_comb begin
      x  = in_lane[i].x;
      y  = in_lane[i].y;
      z  = in_lane[i].z;
      dx = y >>> STEP;
      dy = x >>> STEP;
      pos = VECTORING ? (y > 0) : (z < 0);
      if (pos) begin
        lane_nxt.x = x + dx;
        lane_nxt.y = y - dy;
        lane_nxt.z = z + ATAN_K;
      end else begin
        lane_nxt.x = x - dx;
        lane_nxt.y = y + dy;
        lane_nxt.z = z - ATAN_K;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_r <= lane_nxt;
      end
    end

    assign out_lane[i] = lane_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      carry_r <= in_carry;
    end
  end

  assign out_vld   = vld_r;
  assign out_carry = carry_r;

endmodule

// ----- hw/rtl/qslerp_div_cell.sv -----
`timescale 1ns / 1ps
// One quotient bit of a pipelined restoring divider, shared divisor, several lanes.
// Depends on qslerp_pkg for the lane type and widths.

module qslerp_div_cell #(
  parameter int LANES   = 2,
  parameter int CARRY_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  qslerp_pkg::qs_div_t [LANES-1:0]    in_lane,
  input  logic [qslerp_pkg::DIV_R_W-1:0]     in_d,
  input  logic [CARRY_W-1:0]                 in_carry,
  output logic                               out_vld,
  output qslerp_pkg::qs_div_t [LANES-1:0]    out_lane,
  output logic [qslerp_pkg::DIV_R_W-1:0]     out_d,
  output logic [CARRY_W-1:0]                 out_carry
);
  import qslerp_pkg::*;

  logic               vld_r;
  logic [DIV_R_W-1:0] d_r;
  logic [CARRY_W-1:0] carry_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [DIV_R_W:0] sh, diff;
    logic             ge;
    qs_div_t          lane_nxt, lane_r;

    // The dividend bits shift out of the top of quo while quotient bits enter at the bottom.
    always_comb begin
      sh   = {in_lane[i].rem, in_lane[i].quo[DIV_Q_W-1]};
      diff = sh - {1'b0, in_d};
      ge   = !diff[DIV_R_W];
      lane_nxt.neg = in_lane[i].neg;
      lane_nxt.rem = ge ? diff[DIV_R_W-1:0] : sh[DIV_R_W-1:0];
      lane_nxt.quo = {in_lane[i].quo[DIV_Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_r <= lane_nxt;
      end
    end

    assign out_lane[i] = lane_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      d_r     <= in_d;
      carry_r <= in_carry;
    end
  end

  assign out_vld   = vld_r;
  assign out_d     = d_r;
  assign out_carry = carry_r;

endmodule

// ----- hw/rtl/quaternion_slerp.sv -----
`timescale 1ns / 1ps
// Quaternion slerp top level: dot product, square root, arctangent, sines, division, blend.
// Depends on qslerp_pkg and the qslerp sqrt, cordic and div cells.
//
// Fully pipelined: one request is taken per clock and one result leaves per clock while
// out_ready is high. The pipeline holds the 31-cell square-root row, two CORDIC rows of
// NITER cells each and the 40-cell divider row. A two-entry output buffer holds finished
// results; the pipeline pauses (and in_ready drops) only while both entries are occupied.

module quaternion_slerp #(
  parameter int FRAC_BITS       = 14,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qslerp_pkg::qs_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qslerp_pkg::qs_out_t out_data
);
  import qslerp_pkg::*;

  localparam int NITER = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam int DF = 2 * FRAC_BITS;
  localparam logic [61:0] ONE_DF = 62'(1) << DF;
  localparam logic [61:0] THR = ONE_DF - ONE_DF / 62'd10000;
  localparam int SH_R = (DF >= TRIG_FRAC) ? DF - TRIG_FRAC : 0;
  localparam int SH_L = (DF >= TRIG_FRAC) ? 0 : TRIG_FRAC - DF;
  localparam logic [SQ_W-1:0] RAD_ONE = SQ_W'(1) << (2 * TRIG_FRAC);
  localparam int SIDE_W = $bits(qs_side_t);
  localparam int SQ_CW = SIDE_W + TRIG_FRAC;
  localparam int TR_CW = SIDE_W + 32;
  localparam int SUM_W = K_W + 18;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (TRIG_FRAC - 1);

  logic       en;
  logic [1:0] cnt_r;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // Stage 1: capture and clamp the fraction.
  logic             v1_r;
  logic [3:0][15:0] s1_s_r, s1_e_r;
  logic [15:0]      s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      s1_s_r <= {in_data.start_c3, in_data.start_c2, in_data.start_c1, in_data.start_c0};
      s1_e_r <= {in_data.end_c3, in_data.end_c2, in_data.end_c1, in_data.end_c0};
      s1_t_r <= (in_data.blend_fraction > T_ONE) ? T_ONE : in_data.blend_fraction;
    end
  end

  // Stage 2: four products.
  logic               v2_r;
  logic signed [31:0] s2_p_r [4];
  logic [3:0][15:0]   s2_s_r, s2_e_r;
  logic [15:0]        s2_t_r, s2_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s2_p_r[j] <= $signed(s1_s_r[j]) * $signed(s1_e_r[j]);
      end
      s2_s_r <= s1_s_r;
      s2_e_r <= s1_e_r;
      s2_t_r <= s1_t_r;
      s2_u_r <= T_ONE - s1_t_r;
    end
  end

  // Stage 3: dot product, sign fold, linear test and cosine in the trig domain.
  logic signed [33:0] dot;
  logic               dneg;
  logic [33:0]        adot;
  logic [63:0]        cw;
  qs_side_t           side3;
  logic               v3_r;
  qs_side_t           s3_side_r;
  logic [TRIG_FRAC-1:0] s3_c_r;

  always_comb begin
    dot  = 34'(s2_p_r[0]) + 34'(s2_p_r[1]) + 34'(s2_p_r[2]) + 34'(s2_p_r[3]);
    dneg = dot[33];
    adot = dneg ? 34'(-dot) : 34'(dot);
    cw   = (64'(adot) >> SH_R) << SH_L;
    for (int j = 0; j < 4; j++) begin
      side3.e[j] = dneg ? 17'(-$signed({s2_e_r[j][15], s2_e_r[j]}))
                        : {s2_e_r[j][15], s2_e_r[j]};
    end
    side3.s   = s2_s_r;
    side3.t   = s2_t_r;
    side3.u   = s2_u_r;
    side3.lin = 62'(adot) > THR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      s3_side_r <= side3;
      s3_c_r    <= cw[TRIG_FRAC-1:0];
    end
  end

  // Stages 4 and 5: cosine squared, then the radicand of the sine.
  logic                 v4_r, v5_r;
  qs_side_t             s4_side_r, s5_side_r;
  logic [TRIG_FRAC-1:0] s4_c_r, s5_c_r;
  logic [2*TRIG_FRAC-1:0] s4_c2_r;
  logic [SQ_W-1:0]      s5_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (en) begin
      s4_c2_r   <= s3_c_r * s3_c_r;
      s4_c_r    <= s3_c_r;
      s4_side_r <= s3_side_r;
      s5_rad_r  <= RAD_ONE - SQ_W'(s4_c2_r);
      s5_c_r    <= s4_c_r;
      s5_side_r <= s4_side_r;
    end
  end

  // Square-root row.
  logic             sq_vld   [SQ_STEPS+1];
  logic [SQ_W-1:0]  sq_rem   [SQ_STEPS+1];
  logic [SQ_W-1:0]  sq_res   [SQ_STEPS+1];
  logic [SQ_CW-1:0] sq_carry [SQ_STEPS+1];

  assign sq_vld[0]   = v5_r;
  assign sq_rem[0]   = s5_rad_r;
  assign sq_res[0]   = '0;
  assign sq_carry[0] = {s5_side_r, s5_c_r};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    qslerp_sqrt_cell #(
      .STEP    (k),
      .CARRY_W (SQ_CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (sq_vld[k]),
      .in_rem    (sq_rem[k]),
      .in_res    (sq_res[k]),
      .in_carry  (sq_carry[k]),
      .out_vld   (sq_vld[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_res   (sq_res[k+1]),
      .out_carry (sq_carry[k+1])
    );
  end

  // Stage 6: zero-sine guard and arctangent setup.
  qs_side_t             side6;
  logic [TRIG_FRAC-1:0] c6;
  logic [31:0]          sine6;
  logic                 v6_r;
  qs_side_t             s6_side_r;
  logic [31:0]          s6_sine_r;
  qs_cordic_t [0:0]     s6_lane_r;

  always_comb begin
    side6 = sq_carry[SQ_STEPS][SQ_CW-1 -: SIDE_W];
    c6    = sq_carry[SQ_STEPS][TRIG_FRAC-1:0];
    sine6 = sq_res[SQ_STEPS][31:0];
    if (sine6 == 32'd0) begin
      side6.lin = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= sq_vld[SQ_STEPS];
    end
    if (en) begin
      s6_side_r      <= side6;
      s6_sine_r      <= sine6;
      s6_lane_r[0].x <= ANG_W'(c6);
      s6_lane_r[0].y <= ANG_W'(sine6);
      s6_lane_r[0].z <= '0;
    end
  end

  // Arctangent row.
  logic             at_vld   [NITER+1];
  qs_cordic_t [0:0] at_lane  [NITER+1];
  logic [TR_CW-1:0] at_carry [NITER+1];

  assign at_vld[0]   = v6_r;
  assign at_lane[0]  = s6_lane_r;
  assign at_carry[0] = {s6_side_r, s6_sine_r};

  for (genvar k = 0; k < NITER; k++) begin : g_atan
    qslerp_cordic_cell #(
      .STEP      (k),
      .LANES     (1),
      .VECTORING (1'b1),
      .CARRY_W   (TR_CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (at_vld[k]),
      .in_lane   (at_lane[k]),
      .in_carry  (at_carry[k]),
      .out_vld   (at_vld[k+1]),
      .out_lane  (at_lane[k+1]),
      .out_carry (at_carry[k+1])
    );
  end

  // Stage 7: partial angles (1-t)*angle and t*angle.
  qs_side_t                  side7;
  logic signed [ANG_W-1:0]   ang7;
  logic                      v7_r;
  logic [TR_CW-1:0]          s7_carry_r;
  logic signed [ANG_W+16:0]  s7_p0_r, s7_p1_r;
  logic signed [ANG_W+16:0]  a0_sh, a1_sh;

  always_comb begin
    side7 = at_carry[NITER][TR_CW-1 -: SIDE_W];
    ang7  = at_lane[NITER][0].z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= at_vld[NITER];
    end
    if (en) begin
      s7_p0_r    <= $signed({1'b0, side7.u}) * ang7;
      s7_p1_r    <= $signed({1'b0, side7.t}) * ang7;
      s7_carry_r <= at_carry[NITER];
    end
  end

  // Sine row, two lanes.
  logic             sn_vld   [NITER+1];
  qs_cordic_t [1:0] sn_lane  [NITER+1];
  logic [TR_CW-1:0] sn_carry [NITER+1];

  always_comb begin
    a0_sh = s7_p0_r >>> 15;
    a1_sh = s7_p1_r >>> 15;
    sn_lane[0][0].x = CORDIC_GAIN_INV;
    sn_lane[0][0].y = '0;
    sn_lane[0][0].z = a0_sh[ANG_W-1:0];
    sn_lane[0][1].x = CORDIC_GAIN_INV;
    sn_lane[0][1].y = '0;
    sn_lane[0][1].z = a1_sh[ANG_W-1:0];
  end

  assign sn_vld[0]   = v7_r;
  assign sn_carry[0] = s7_carry_r;

  for (genvar k = 0; k < NITER; k++) begin : g_sin
    qslerp_cordic_cell #(
      .STEP      (k),
      .LANES     (2),
      .VECTORING (1'b0),
      .CARRY_W   (TR_CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (sn_vld[k]),
      .in_lane   (sn_lane[k]),
      .in_carry  (sn_carry[k]),
      .out_vld   (sn_vld[k+1]),
      .out_lane  (sn_lane[k+1]),
      .out_carry (sn_carry[k+1])
    );
  end

  // Stage 8: divider setup, sign and magnitude of each sine scaled by 2^30.
  qs_div_t [1:0] div8;
  logic          v8_r;
  qs_div_t [1:0] s8_lane_r;
  qs_side_t      s8_side_r;
  logic [31:0]   s8_d_r;

  for (genvar i = 0; i < 2; i++) begin : g_dinit
    logic signed [ANG_W-1:0] y;
    logic [ANG_W-1:0]        mag;
    logic [31+TRIG_FRAC:0]   num;

    always_comb begin
      y   = sn_lane[NITER][i].y;
      mag = y[ANG_W-1] ? ANG_W'(-y) : ANG_W'(y);
      num = {mag[31:0], TRIG_FRAC'(0)};
      div8[i].neg = y[ANG_W-1];
      div8[i].rem = DIV_R_W'(num[31+TRIG_FRAC:DIV_Q_W]);
      div8[i].quo = num[DIV_Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= sn_vld[NITER];
    end
    if (en) begin
      s8_lane_r <= div8;
      s8_side_r <= sn_carry[NITER][TR_CW-1 -: SIDE_W];
      s8_d_r    <= sn_carry[NITER][31:0];
    end
  end

  // Divider row.
  logic               dv_vld   [DIV_Q_W+1];
  qs_div_t [1:0]      dv_lane  [DIV_Q_W+1];
  logic [DIV_R_W-1:0] dv_d     [DIV_Q_W+1];
  logic [SIDE_W-1:0]  dv_carry [DIV_Q_W+1];

  assign dv_vld[0]   = v8_r;
  assign dv_lane[0]  = s8_lane_r;
  assign dv_d[0]     = s8_d_r;
  assign dv_carry[0] = s8_side_r;

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_div
    qslerp_div_cell #(
      .LANES   (2),
      .CARRY_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (dv_vld[k]),
      .in_lane   (dv_lane[k]),
      .in_d      (dv_d[k]),
      .in_carry  (dv_carry[k]),
      .out_vld   (dv_vld[k+1]),
      .out_lane  (dv_lane[k+1]),
      .out_d     (dv_d[k+1]),
      .out_carry (dv_carry[k+1])
    );
  end

  // Stage 9: signed weights, or linear weights when the quaternions nearly coincide (or oppose).
  qs_side_t               side9;
  logic signed [K_W-1:0]  kq0, kq1;
  logic                   v9_r;
  qs_side_t               s9_side_r;
  logic signed [K_W-1:0]  s9_k0_r, s9_k1_r;

  always_comb begin
    side9 = dv_carry[DIV_Q_W];
    kq0 = $signed({1'b0, dv_lane[DIV_Q_W][0].quo});
    kq1 = $signed({1'b0, dv_lane[DIV_Q_W][1].quo});
    if (dv_lane[DIV_Q_W][0].neg) begin
      kq0 = -kq0;
    end
    if (dv_lane[DIV_Q_W][1].neg) begin
      kq1 = -kq1;
    end
    if (side9.lin) begin
      kq0 = K_W'({side9.u, 15'd0});
      kq1 = K_W'({side9.t, 15'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= dv_vld[DIV_Q_W];
    end
    if (en) begin
      s9_side_r <= side9;
      s9_k0_r   <= kq0;
      s9_k1_r   <= kq1;
    end
  end

  // Stage 10: the eight weighted terms.
  logic                    v10_r;
  logic signed [K_W+16:0]  s10_ps_r [4];
  logic signed [K_W+16:0]  s10_pe_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
    end
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s10_ps_r[j] <= $signed(s9_side_r.s[j]) * s9_k0_r;
        s10_pe_r[j] <= $signed(s9_side_r.e[j]) * s9_k1_r;
      end
    end
  end

  // Round, scale back to 14 fraction bits and saturate.
  logic signed [15:0] comp [4];
  qs_out_t            res;

  for (genvar j = 0; j < 4; j++) begin : g_blend
    logic signed [SUM_W-1:0] sum, shv;

    always_comb begin
      sum = SUM_W'(s10_ps_r[j]) + SUM_W'(s10_pe_r[j]) + ROUND;
      shv = sum >>> TRIG_FRAC;
      if (shv > SUM_W'(32767)) begin
        comp[j] = 16'sh7fff;
      end else if (shv < -SUM_W'(32768)) begin
        comp[j] = 16'sh8000;
      end else begin
        comp[j] = shv[15:0];
      end
    end
  end

  assign res.out_c0 = comp[0];
  assign res.out_c1 = comp[1];
  assign res.out_c2 = comp[2];
  assign res.out_c3 = comp[3];

  // Two-entry output buffer.
  logic    push, pop;
  qs_out_t slot0_r, slot1_r;

  assign push      = en && v10_r;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))) begin
      slot0_r <= res;
    end else if ((cnt_r == 2'd2) && pop) begin
      slot0_r <= slot1_r;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      slot1_r <= res;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion_slerp pipeline: random and directed requests,
// a bit-exact fixed-point slerp predictor, and an in-order result check.
// Depends on qslerp_pkg and the quaternion_slerp RTL.

module tb;
  import qslerp_pkg::*;

  localparam int LATENCY = 82 + 2 * 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 950;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  qs_in_t  in_data;
  logic    out_valid;
  logic    out_ready;
  qs_out_t out_data;

  qs_in_t  pending_requests[$];
  qs_out_t expected_slerps[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      quiet_tail = 1'b0;
  bit      sender_hold;
  bit      sender_hold_done;
  int      sender_gap;
  int      receiver_gap;
  int      receiver_hold;
  bit      receiver_hold_done;

  quaternion_slerp DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arc_tangent(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(longint z);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    return y;
  endfunction

  function automatic qs_out_t slerp_of(qs_in_t req);
    longint s[4];
    longint e[4];
    longint dot;
    longint t;
    longint u;
    longint k0;
    longint k1;
    longint c;
    longint sine;
    longint ang;
    longint v;
    longint unsigned c2;
    logic signed [15:0] r[4];
    qs_out_t res;
    s[0] = req.start_c0; s[1] = req.start_c1; s[2] = req.start_c2; s[3] = req.start_c3;
    e[0] = req.end_c0; e[1] = req.end_c1; e[2] = req.end_c2; e[3] = req.end_c3;
    dot = 0;
    for (int j = 0; j < 4; j++) dot += s[j] * e[j];
    t = req.blend_fraction > 16'd32768 ? 32768 : longint'(req.blend_fraction);
    u = 32768 - t;
    if (dot < 0) begin
      for (int j = 0; j < 4; j++) e[j] = -e[j];
      dot = -dot;
    end
    k0 = u * 32768;
    k1 = t * 32768;
    if (dot <= (longint'(1) << 28) - (longint'(1) << 28) / 10000) begin
      c = dot * 4;
      c2 = longint'(c) * longint'(c);
      sine = int_sqrt((64'd1 << 60) - c2);
      if (sine > 0) begin
        ang = arc_tangent(sine, c);
        k0 = (sine_of(floor_shr(u * ang, 15)) * (longint'(1) << 30)) / sine;
        k1 = (sine_of(floor_shr(t * ang, 15)) * (longint'(1) << 30)) / sine;
      end
    end
    for (int j = 0; j < 4; j++) begin
      v = floor_shr(s[j] * k0 + e[j] * k1 + (longint'(1) << 29), 30);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r[j] = v[15:0];
    end
    res.out_c0 = r[0]; res.out_c1 = r[1]; res.out_c2 = r[2]; res.out_c3 = r[3];
    return res;
  endfunction

  function automatic logic [15:0] rand_comp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h8000;
    if (pick == 1) return 16'h7FFF;
    if (pick < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    return 16'($urandom);
  endfunction

  function automatic qs_in_t rand_request();
    qs_in_t q;
    int pick;
    q.start_c0 = rand_comp(); q.start_c1 = rand_comp();
    q.start_c2 = rand_comp(); q.start_c3 = rand_comp();
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      // Nearly equal (or opposite) quaternions: linear blend path if their dot product is large.
      q.end_c0 = q.start_c0 + 16'($signed($urandom_range(0, 4)) - 2);
      q.end_c1 = q.start_c1; q.end_c2 = q.start_c2; q.end_c3 = q.start_c3;
      if ($urandom_range(0, 1)) begin
        q.end_c0 = -q.end_c0; q.end_c1 = -q.end_c1;
        q.end_c2 = -q.end_c2; q.end_c3 = -q.end_c3;
      end
    end else begin
      q.end_c0 = rand_comp(); q.end_c1 = rand_comp();
      q.end_c2 = rand_comp(); q.end_c3 = rand_comp();
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) q.blend_fraction = 16'($urandom);
    else if (pick == 1) q.blend_fraction = $urandom_range(0, 1) ? 16'd0 : 16'd32768;
    else q.blend_fraction = 16'($urandom_range(0, 32768));
    return q;
  endfunction

  function automatic qs_in_t make_request(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                                          logic [15:0] s3, logic [15:0] e0, logic [15:0] e1,
                                          logic [15:0] e2, logic [15:0] e3, logic [15:0] t);
    qs_in_t q;
    q.start_c0 = s0; q.start_c1 = s1; q.start_c2 = s2; q.start_c3 = s3;
    q.end_c0 = e0; q.end_c1 = e1; q.end_c2 = e2; q.end_c3 = e3;
    q.blend_fraction = t;
    return q;
  endfunction

  // Directed set: identity pairs, orthogonal and opposite quaternions, extreme components,
  // fractions at 0, 1 and above 1, and unnormalized inputs whose dot product exceeds one.
  initial begin
    pending_requests.push_back(make_request(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
    pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
    pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
    pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 16'hFFFF));
    pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 32769));
    pending_requests.push_back(make_request(16384, 0, 0, 0, -16384, 0, 0, 0, 8192));
    pending_requests.push_back(make_request(8192, 8192, 8192, 8192, -8192, 8192, -8192,
                                            -8192, 12000));
    pending_requests.push_back(make_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16384));
    pending_requests.push_back(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 5));
    pending_requests.push_back(make_request(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                            16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 30000));
    pending_requests.push_back(make_request(16'h7FFF, 0, 0, 0, 0, 16'h7FFF, 0, 0, 16384));
    pending_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 16384));
    pending_requests.push_back(make_request(11585, 11585, 0, 0, 16384, 0, 0, 0, 1));
    pending_requests.push_back(make_request(16384, 1, 0, 0, 16384, 0, 0, 0, 20000));
    pending_requests.push_back(make_request(16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555,
                                            16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'hAAAA));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_requests.push_back(rand_request());
  end

  // Sender: bursts of idle cycles, one pause that waits for the pipeline to drain.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      sender_gap <= 0;
      sender_hold <= 1'b0;
      sender_hold_done <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // Request held until accepted.
    end else if (sender_hold) begin
      if (expected_slerps.size() == 0) sender_hold <= 1'b0;
      in_valid <= 1'b0;
    end else if (sender_gap > 0) begin
      sender_gap <= sender_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_requests.size() > 0) begin
      if (pending_requests.size() <= 500 && !sender_hold_done) begin
        sender_hold <= 1'b1;
        sender_hold_done <= 1'b1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        sender_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_slerps.push_back(slerp_of(in_data));
  end

  // Receiver: short random stalls and one long hold that backs up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      receiver_gap <= 0;
      receiver_hold <= 0;
      receiver_hold_done <= 1'b0;
    end else if (receiver_hold > 0) begin
      receiver_hold <= receiver_hold - 1;
      out_ready <= 1'b0;
    end else if (pending_requests.size() <= 800 && !receiver_hold_done) begin
      receiver_hold <= 3 * LATENCY;
      receiver_hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (receiver_gap > 0) begin
      receiver_gap <= receiver_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      receiver_gap <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    qs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_slerps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_slerps.pop_front();
        if (want.out_c0 !== out_data.out_c0)
          $display("%0t: out_c0 expected %0d actual %0d", $time, want.out_c0, out_data.out_c0);
        if (want.out_c1 !== out_data.out_c1)
          $display("%0t: out_c1 expected %0d actual %0d", $time, want.out_c1, out_data.out_c1);
        if (want.out_c2 !== out_data.out_c2)
          $display("%0t: out_c2 expected %0d actual %0d", $time, want.out_c2, out_data.out_c2);
        if (want.out_c3 !== out_data.out_c3)
          $display("%0t: out_c3 expected %0d actual %0d", $time, want.out_c3, out_data.out_c3);
        if (want !== out_data) error_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (pending_requests.size() < 100) quiet_tail <= 1'b1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_requests.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_slerps.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_slerps.size() == 0 && !out_valid) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
